// ----- rtl/core/hsv2rgb_pkg.sv -----
// Shared types and constants for the HSV to RGB pixel converter.
package hsv2rgb_pkg;

    // Sector of the hue circle, each one sixth of a turn
    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } hsv2rgb_sector_t;

    localparam logic [7:0]  FULL_SCALE = 8'd255;
    localparam logic [16:0] FRAC_ONE   = 17'h10000;
    // 255 * 65536, the common denominator of q and t
    localparam logic [23:0] TERM_DEN   = 24'd16711680;
    // ceil(2^23 / 255): exact quotient by 255 for any 16-bit numerator used here
    localparam logic [15:0] RECIP_255  = 16'd32897;

    // Numerators of p, q and t, each still to be divided by 255
    typedef struct packed {
        logic [2:0]  sector;
        logic [7:0]  v;
        logic [15:0] p_num;
        logic [15:0] q_num;
        logic [15:0] t_num;
    } hsv2rgb_num_t;

endpackage

// ----- rtl/core/hsv_to_rgb_converter.sv -----
// Top level of the HSV to RGB pixel converter.
// Converts one pixel per clock unless stalled: hue (16-bit fraction of a turn), saturation
// and value (255 = 1.0) in, truncated 8-bit red, green and blue out. The datapath is a
// five-stage pipeline (sector split, saturation products, value products, divide by 255,
// channel select): out_valid rises once a transfer reaches the last stage register, and
// the result transfers when the output is not stalled. A transfer can be taken every cycle
// unless stalled; each stage holds one pixel, so up to five pixels are in flight and the
// input stalls only once every stage is full behind a stalled output.
module hsv_to_rgb_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] hue,
    input  logic [7:0]  saturation,
    input  logic [7:0]  brightness_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out
);
    import hsv2rgb_pkg::*;

    logic         mid_valid;
    logic         mid_stall;
    hsv2rgb_num_t mid_num;

    hsv2rgb_terms u_terms (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .hue              (hue),
        .saturation       (saturation),
        .brightness_value (brightness_value),
        .out_valid        (mid_valid),
        .out_stall        (mid_stall),
        .out_num          (mid_num)
    );

    hsv2rgb_quot u_quot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_stall  (mid_stall),
        .in_num    (mid_num),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

endmodule

// ----- rtl/core/hsv2rgb_terms.sv -----
// Three pipeline stages: hue sector split, saturation products, value products.
module hsv2rgb_terms (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [15:0]               hue,
    input  logic [7:0]                saturation,
    input  logic [7:0]                brightness_value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output hsv2rgb_pkg::hsv2rgb_num_t out_num
);
    import hsv2rgb_pkg::*;

    logic        vld1_reg, vld2_reg, vld3_reg;
    logic        rdy1, rdy2, rdy3;

    logic [18:0] scaled;
    logic [2:0]  sec1_reg;
    logic [15:0] f1_reg;
    logic [7:0]  s1_reg;
    logic [7:0]  v1_reg;

    logic [23:0] fs;
    logic [16:0] g;
    logic [24:0] gs;
    logic [24:0] mt_full;
    logic [23:0] mq;
    logic [15:0] pnum;
    logic [2:0]  sec2_reg;
    logic [7:0]  v2_reg;
    logic [23:0] mq2_reg;
    logic [23:0] mt2_reg;
    logic [15:0] pnum2_reg;

    logic [31:0] nq;
    logic [31:0] nt;
    hsv2rgb_num_t num3_reg;

    // A stage takes new data when it is empty or its contents move on
    assign rdy3     = !vld3_reg || !out_stall;
    assign rdy2     = !vld2_reg || rdy3;
    assign rdy1     = !vld1_reg || rdy2;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                vld1_reg <= in_valid;
            end
            if (rdy2)
            begin
                vld2_reg <= vld1_reg;
            end
            if (rdy3)
            begin
                vld3_reg <= vld2_reg;
            end
        end
    end

    // hue * 6 as shift-add; top three bits are the sector
    assign scaled = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            sec1_reg <= scaled[18:16];
            f1_reg   <= scaled[15:0];
            s1_reg   <= saturation;
            v1_reg   <= brightness_value;
        end
    end

    assign fs      = 24'(f1_reg) * 24'(s1_reg);
    assign g       = FRAC_ONE - {1'b0, f1_reg};
    assign gs      = 25'(g) * 25'(s1_reg);
    assign mq      = TERM_DEN - fs;
    assign mt_full = {1'b0, TERM_DEN} - gs;
    assign pnum    = 16'(v1_reg) * 16'(FULL_SCALE - s1_reg);

    always_ff @(posedge clk)
    begin
        if (rdy2 && vld1_reg)
        begin
            sec2_reg  <= sec1_reg;
            v2_reg    <= v1_reg;
            mq2_reg   <= mq;
            mt2_reg   <= mt_full[23:0];
            pnum2_reg <= pnum;
        end
    end

    // Dropping the low 16 bits first leaves only a divide by 255
    assign nq = 32'(v2_reg) * 32'(mq2_reg);
    assign nt = 32'(v2_reg) * 32'(mt2_reg);

    always_ff @(posedge clk)
    begin
        if (rdy3 && vld2_reg)
        begin
            num3_reg.sector <= sec2_reg;
            num3_reg.v      <= v2_reg;
            num3_reg.p_num  <= pnum2_reg;
            num3_reg.q_num  <= nq[31:16];
            num3_reg.t_num  <= nt[31:16];
        end
    end

    assign out_valid = vld3_reg;
    assign out_num   = num3_reg;

endmodule

// ----- rtl/core/hsv2rgb_quot.sv -----
// Two pipeline stages: divide by 255 via reciprocal, then sector channel mapping.
module hsv2rgb_quot (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  hsv2rgb_pkg::hsv2rgb_num_t in_num,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                red_out,
    output logic [7:0]                green_out,
    output logic [7:0]                blue_out
);
    import hsv2rgb_pkg::*;

    logic        vld4_reg, vld5_reg;
    logic        rdy4, rdy5;

    logic [31:0] prod_p, prod_q, prod_t;
    logic [2:0]  sec4_reg;
    logic [7:0]  v4_reg, p4_reg, q4_reg, t4_reg;

    logic [7:0]  red_next, green_next, blue_next;
    logic [7:0]  red_reg, green_reg, blue_reg;

    assign rdy5     = !vld5_reg || !out_stall;
    assign rdy4     = !vld4_reg || rdy5;
    assign in_stall = !rdy4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end
        else
        begin
            if (rdy4)
            begin
                vld4_reg <= in_valid;
            end
            if (rdy5)
            begin
                vld5_reg <= vld4_reg;
            end
        end
    end

    // Numerators are at most 65025, so the product stays below 2^31
    assign prod_p = 32'(in_num.p_num) * 32'(RECIP_255);
    assign prod_q = 32'(in_num.q_num) * 32'(RECIP_255);
    assign prod_t = 32'(in_num.t_num) * 32'(RECIP_255);

    always_ff @(posedge clk)
    begin
        if (rdy4 && in_valid)
        begin
            sec4_reg <= in_num.sector;
            v4_reg   <= in_num.v;
            p4_reg   <= prod_p[30:23];
            q4_reg   <= prod_q[30:23];
            t4_reg   <= prod_t[30:23];
        end
    end

    always_comb
    begin
        case (hsv2rgb_sector_t'(sec4_reg))
            SEC_RED_YELLOW:
            begin
                red_next = v4_reg; green_next = t4_reg; blue_next = p4_reg;
            end
            SEC_YELLOW_GREEN:
            begin
                red_next = q4_reg; green_next = v4_reg; blue_next = p4_reg;
            end
            SEC_GREEN_CYAN:
            begin
                red_next = p4_reg; green_next = v4_reg; blue_next = t4_reg;
            end
            SEC_CYAN_BLUE:
            begin
                red_next = p4_reg; green_next = q4_reg; blue_next = v4_reg;
            end
            SEC_BLUE_MAGENTA:
            begin
                red_next = t4_reg; green_next = p4_reg; blue_next = v4_reg;
            end
            default:
            begin
                red_next = v4_reg; green_next = p4_reg; blue_next = q4_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy5 && vld4_reg)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = vld5_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

endmodule

// ----- rtl/core/hsv2rgb_checker.sv -----
// Port-level assertions for the HSV to RGB converter, bound to the top level.
module hsv2rgb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [15:0] hue,
    input logic [7:0]  saturation,
    input logic [7:0]  brightness_value,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  red_out,
    input logic [7:0]  green_out,
    input logic [7:0]  blue_out
);

    // Input backs up only when the whole pipeline sits behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output side can drain");

    // With no output stall, a transfer comes out after exactly five stages
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(in_valid && !in_stall && rst_n, 5) &&
         $past(!out_stall && rst_n, 1) && $past(!out_stall && rst_n, 2) &&
         $past(!out_stall && rst_n, 3) && $past(!out_stall && rst_n, 4))
        |-> out_valid)
        else $error("pixel did not reach output after pipeline latency");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("output valid dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            ($stable(red_out) && $stable(green_out) && $stable(blue_out)))
        else $error("output payload changed while stalled");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);

// ----- test/tb_top.sv -----
// Testbench for the HSV to RGB pixel converter: random and directed pixels, scoreboard check.
module tb_top;
    import hsv2rgb_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 1200;
    localparam int unsigned CALM_FIRST   = 500;
    localparam int unsigned CALM_LAST    = 800;
    localparam int unsigned DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Expected colors of pixels in flight, oldest first
    class rgb_scoreboard;
        rgb_t        rgb_pending_q[$];
        int unsigned pixels_noted;
        int unsigned pixels_checked;
        int unsigned errors;

        function rgb_t convert_pixel(logic [15:0] h, logic [7:0] s, logic [7:0] v);
            longint unsigned den;
            longint unsigned frac;
            longint unsigned sat;
            longint unsigned val;
            longint unsigned p;
            longint unsigned q;
            longint unsigned t;
            logic [18:0]     scaled;
            hsv2rgb_sector_t sector;
            rgb_t            rgb;
            den    = 64'd255 * 64'd65536;
            scaled = 19'(h) * 19'd6;
            sector = hsv2rgb_sector_t'(scaled[18:16]);
            frac   = 64'(scaled[15:0]);
            sat    = 64'(s);
            val    = 64'(v);
            p = (val * (64'd255 - sat)) / 64'd255;
            q = (val * (den - frac * sat)) / den;
            t = (val * (den - (64'd65536 - frac) * sat)) / den;
            case (sector)
                SEC_RED_YELLOW:   rgb = '{8'(val), 8'(t), 8'(p)};
                SEC_YELLOW_GREEN: rgb = '{8'(q), 8'(val), 8'(p)};
                SEC_GREEN_CYAN:   rgb = '{8'(p), 8'(val), 8'(t)};
                SEC_CYAN_BLUE:    rgb = '{8'(p), 8'(q), 8'(val)};
                SEC_BLUE_MAGENTA: rgb = '{8'(t), 8'(p), 8'(val)};
                default:          rgb = '{8'(val), 8'(p), 8'(q)};
            endcase
            return rgb;
        endfunction

        function void note_pixel(logic [15:0] h, logic [7:0] s, logic [7:0] v);
            rgb_pending_q.push_back(convert_pixel(h, s, v));
            pixels_noted++;
        endfunction

        function void check_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            rgb_t want;
            if (rgb_pending_q.size() == 0)
            begin
                $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $time, r, g, b);
                errors++;
                return;
            end
            want = rgb_pending_q.pop_front();
            pixels_checked++;
            if (r !== want.red)
            begin
                $display("%0t: red expected %0d, actual %0d", $time, want.red, r);
                errors++;
            end
            if (g !== want.green)
            begin
                $display("%0t: green expected %0d, actual %0d", $time, want.green, g);
                errors++;
            end
            if (b !== want.blue)
            begin
                $display("%0t: blue expected %0d, actual %0d", $time, want.blue, b);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return rgb_pending_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] hue = '0;
    logic [7:0]  saturation = '0;
    logic [7:0]  brightness_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;

    rgb_scoreboard sb = new();
    bit            calm = 1'b0;
    int unsigned   stall_left = 0;
    int unsigned   cycle_count = 0;
    int unsigned   held_off_cycles = 0;
    int unsigned   directed_items = 0;

    hsv_to_rgb_converter uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .hue              (hue),
        .saturation       (saturation),
        .brightness_value (brightness_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .red_out          (red_out),
        .green_out        (green_out),
        .blue_out         (blue_out)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Both transfers are noted in one process so the order within a step is fixed
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_pixel(hue, saturation, brightness_value);
            if (in_valid && in_stall)
                held_off_cycles++;
            if (out_valid && !out_stall)
                sb.check_rgb(red_out, green_out, blue_out);
        end
    end

    // Output stalls come in bursts so the pipeline fills and pushes back on the input
    always @(posedge clk)
    begin
        if (!rst_n || calm)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(99) == 0)
        begin
            stall_left = $urandom_range(11);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d pixels outstanding", $time, sb.pending());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_pixel(input logic [15:0] h, input logic [7:0] s, input logic [7:0] v);
        hue              <= h;
        saturation       <= s;
        brightness_value <= v;
        in_valid         <= 1'b1;
        do @(posedge clk); while (in_stall);
        if (!calm && $urandom_range(99) < 2)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic push_random_pixel();
        logic [15:0] h;
        logic [7:0]  s;
        logic [7:0]  v;
        h = 16'($urandom);
        s = 8'($urandom);
        v = 8'($urandom);
        case ($urandom_range(7))
            // around a sector edge, including the wrap at a full turn
            0: h = 16'($urandom_range(5) * 10923 + $urandom_range(4) - 2);
            1: s = $urandom_range(1) ? 8'd255 : 8'd0;
            2: v = $urandom_range(1) ? 8'd255 : 8'd0;
            default: ;
        endcase
        push_pixel(h, s, v);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, grey, sector starts and both sides of each sector edge
        push_pixel(16'd0,     8'd255, 8'd255);
        push_pixel(16'd65535, 8'd255, 8'd255);
        push_pixel(16'd65535, 8'd0,   8'd0);
        push_pixel(16'd0,     8'd0,   8'd255);
        push_pixel(16'd40000, 8'd0,   8'd100);
        push_pixel(16'd32768, 8'd200, 8'd255);
        push_pixel(16'd10922, 8'd255, 8'd255);
        push_pixel(16'd10923, 8'd255, 8'd255);
        push_pixel(16'd21845, 8'd255, 8'd255);
        push_pixel(16'd21846, 8'd255, 8'd255);
        push_pixel(16'd32767, 8'd255, 8'd255);
        push_pixel(16'd43690, 8'd255, 8'd255);
        push_pixel(16'd43691, 8'd255, 8'd255);
        push_pixel(16'd54613, 8'd255, 8'd255);
        push_pixel(16'd54614, 8'd255, 8'd255);
        push_pixel(16'd50000, 8'd255, 8'd0);
        push_pixel(16'd20000, 8'd1,   8'd254);
        push_pixel(16'd12345, 8'd128, 8'd77);
        push_pixel(16'd60000, 8'd170, 8'd85);
        drain_pipeline();
        directed_items = sb.pixels_noted;

        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= CALM_FIRST && i < CALM_LAST);
            if (i == 900)
                drain_pipeline();
            push_random_pixel();
        end
        calm = 1'b0;

        drain_pipeline();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0t: %0d expected pixels never came out", $time, sb.pending());
            sb.errors++;
        end

        $display("Ran %0d pixels (%0d directed edge cases), %0d results compared, %0d errors",
                 sb.pixels_noted, directed_items, sb.pixels_checked, sb.errors);
        $display("Input held off on %0d cycles; random items %0d to %0d ran with no idling",
                 held_off_cycles, CALM_FIRST, CALM_LAST - 1);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv2rgb_terms.sv
rtl/core/hsv2rgb_quot.sv
rtl/core/hsv_to_rgb_converter.sv
rtl/core/hsv2rgb_checker.sv
test/tb_top.sv
